@@ rtl/core/bea_pkg.sv @@
package bea_pkg;

  localparam int unsigned NumBlocksDef = 32768;
  localparam int unsigned MaxExtentsDef = 64;
  localparam int unsigned BytesPerBlockDef = 512;
  localparam logic [15:0] TotalBlocksRst = 16'd19531;

  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_t;

  typedef enum logic {
    MODE_FORMAT = 1'b0,
    MODE_ALLOC = 1'b1
  } mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FMT,
    S_DIV,
    S_SCAN_RD,
    S_SCAN,
    S_EMIT_RD,
    S_MARK_RD,
    S_MARK_WR,
    S_EMIT,
    S_ONE
  } state_t;

endpackage

@@ rtl/core/bitmap_extent_allocator.sv @@
// format: writes one map word per cycle over the map; allocate: a restoring division, a scan
// of the blocks below the volume end, then a read and a write of each map word an extent covers
// and an output transfer per extent, which waits while out_tready is low
// throughput: one item at a time; a new item is taken only in idle with no result pending
// reset: clears control state and runs a clearing pass over the map,
// during which no item is accepted; total_blocks returns to 19531
module bitmap_extent_allocator #(
  parameter int unsigned NUM_BLOCKS = bea_pkg::NumBlocksDef,
  parameter int unsigned MAX_EXTENTS = bea_pkg::MaxExtentsDef,
  parameter int unsigned BYTES_PER_BLOCK = bea_pkg::BytesPerBlockDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // blocks_required [15:0], min_extent [31:16]
  input  logic [bea_pkg::InDataW-1:0]   in_tdata,
  // mode
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // extent_start [14:0], extent_count [30:15], zero pad [31]
  output logic [bea_pkg::OutDataW-1:0]  out_tdata,
  // status
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);
  import bea_pkg::*;

  localparam int unsigned Words = (NUM_BLOCKS + 63) / 64;
  localparam int unsigned WAW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BAW = $clog2(NUM_BLOCKS) + 1;
  localparam int unsigned XAW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned XCW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned BpbLog = $clog2(BYTES_PER_BLOCK);

  // map memory, one read and one write port
  logic [63:0] map_mem [Words];
  logic [63:0] rd_q;
  logic [WAW-1:0] rd_a;
  logic rd_en;
  logic wr_en;
  logic [WAW-1:0] wr_a;
  logic [63:0] wr_d;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_a] <= wr_d;
    end
    if (rd_en) begin
      rd_q <= map_mem[rd_a];
    end
  end

  // found extent memory
  logic [29:0] ext_mem [MAX_EXTENTS];
  logic [29:0] ext_q;
  logic ext_we;
  logic [XAW-1:0] ext_wa;
  logic [29:0] ext_wd;
  logic [XAW-1:0] ext_ra;

  always_ff @(posedge clk) begin
    if (ext_we) begin
      ext_mem[ext_wa] <= ext_wd;
    end
    ext_q <= ext_mem[ext_ra];
  end

  state_t st_r, st_nxt;
  logic [15:0] tot_r;
  logic [BAW-1:0] b_r, b_nxt;
  logic [BAW-1:0] rs_r, rs_nxt;
  logic [16:0] run_r, run_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] req_r, req_nxt;
  logic [15:0] minx_r, minx_nxt;
  logic [XCW-1:0] n_r, n_nxt;
  logic [XCW-1:0] i_r, i_nxt;
  logic [16:0] mk_r, mk_nxt;      // blocks still to mark in the current extent
  logic [BAW-1:0] mb_r, mb_nxt;   // current mark block
  logic [16:0] q_r, q_nxt;        // quotient / remainder for needed count
  logic [16:0] dr_r, dr_nxt;
  logic [4:0] dc_r, dc_nxt;
  logic [WAW:0] cw_r, cw_nxt;
  logic [16:0] fres_r, fres_nxt;
  logic ov_r, ov_nxt;
  logic [14:0] os_r, os_nxt;
  logic [15:0] oc_r, oc_nxt;
  logic ol_r, ol_nxt;
  logic [1:0] ost_r, ost_nxt;

  logic [BAW-1:0] limit;
  assign limit = (32'(tot_r) < NUM_BLOCKS) ? BAW'(tot_r) : BAW'(NUM_BLOCKS);

  logic [16:0] reserved;
  assign reserved = 17'd1 + 17'(({4'd0, tot_r[15:3]} + 17'(BYTES_PER_BLOCK - 1)) >> BpbLog);

  logic [16:0] want;
  assign want = (rem_r < {1'b0, minx_r}) ? rem_r : {1'b0, minx_r};

  logic [16:0] dsub;
  logic [16:0] dtry;

  assign cfg_ready = (st_r == S_IDLE);
  assign in_tready = (st_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = {1'b0, oc_r, os_r};
  assign out_tuser = ost_r;
  assign out_tlast = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      tot_r <= TotalBlocksRst;
      ov_r <= 1'b0;
      cw_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      cw_r <= cw_nxt;
      if (cfg_valid && cfg_ready) begin
        tot_r <= cfg_data;
      end
    end
    b_r <= b_nxt;
    rs_r <= rs_nxt;
    run_r <= run_nxt;
    rem_r <= rem_nxt;
    req_r <= req_nxt;
    minx_r <= minx_nxt;
    n_r <= n_nxt;
    i_r <= i_nxt;
    mk_r <= mk_nxt;
    mb_r <= mb_nxt;
    q_r <= q_nxt;
    dr_r <= dr_nxt;
    dc_r <= dc_nxt;
    fres_r <= fres_nxt;
    os_r <= os_nxt;
    oc_r <= oc_nxt;
    ol_r <= ol_nxt;
    ost_r <= ost_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    ov_nxt = ov_r;
    cw_nxt = cw_r;
    b_nxt = b_r;
    rs_nxt = rs_r;
    run_nxt = run_r;
    rem_nxt = rem_r;
    req_nxt = req_r;
    minx_nxt = minx_r;
    n_nxt = n_r;
    i_nxt = i_r;
    mk_nxt = mk_r;
    mb_nxt = mb_r;
    q_nxt = q_r;
    dr_nxt = dr_r;
    dc_nxt = dc_r;
    fres_nxt = fres_r;
    os_nxt = os_r;
    oc_nxt = oc_r;
    ol_nxt = ol_r;
    ost_nxt = ost_r;
    rd_en = 1'b0;
    rd_a = b_r[WAW+5:6];
    wr_en = 1'b0;
    wr_a = cw_r[WAW-1:0];
    wr_d = '0;
    ext_we = 1'b0;
    ext_wa = n_r[XAW-1:0];
    ext_wd = {rs_r[14:0], 15'(want)};
    ext_ra = i_r[XAW-1:0];
    dtry = {dr_r[15:0], q_r[16]};
    dsub = dtry - {1'b0, minx_r};
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      S_CLEAR, S_FMT: begin
        // sweep one word a cycle; format also sets the reserved prefix
        wr_en = 1'b1;
        for (int k = 0; k < 64; k++) begin
          wr_d[k] = (st_r == S_FMT) &&
                    ({cw_r[WAW-1:0], 6'(k)} < 22'(fres_r));
        end
        cw_nxt = cw_r + 1'b1;
        if (cw_r == (WAW+1)'(Words - 1)) begin
          cw_nxt = '0;
          if (st_r == S_FMT) begin
            st_nxt = S_ONE;
            os_nxt = '0;
            oc_nxt = fres_r[15:0];
            ost_nxt = ST_OK;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt = in_tdata[15:0];
          minx_nxt = (in_tdata[31:16] == 16'd0) ? 16'd1 : in_tdata[31:16];
          if (in_tuser == MODE_FORMAT) begin
            fres_nxt = reserved;
            cw_nxt = '0;
            st_nxt = S_FMT;
          end else if (in_tdata[15:0] == 16'd0) begin
            os_nxt = '0;
            oc_nxt = '0;
            ost_nxt = ST_OK;
            st_nxt = S_ONE;
          end else begin
            // needed = floor((req - 1) / minx) + 1, restoring division
            q_nxt = {1'b0, in_tdata[15:0] - 16'd1};
            dr_nxt = '0;
            dc_nxt = 5'd17;
            st_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!dsub[16]) begin
          dr_nxt = dsub;
        end else begin
          dr_nxt = dtry;
        end
        q_nxt = {q_r[15:0], !dsub[16]};
        dc_nxt = dc_r - 5'd1;
        if (dc_r == 5'd1) begin
          if ({q_r[15:0], !dsub[16]} >= 17'(MAX_EXTENTS)) begin
            os_nxt = '0;
            oc_nxt = '0;
            ost_nxt = ST_TOO_MANY;
            st_nxt = S_ONE;
          end else begin
            rem_nxt = {1'b0, req_r};
            run_nxt = '0;
            n_nxt = '0;
            b_nxt = '0;
            st_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (b_r >= limit || rem_r == 17'd0) begin
          if (rem_r != 17'd0 || n_r == '0) begin
            os_nxt = '0;
            oc_nxt = '0;
            ost_nxt = ST_NO_SPACE;
            st_nxt = S_ONE;
          end else begin
            i_nxt = '0;
            st_nxt = S_EMIT_RD;
          end
        end else begin
          rd_en = 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        st_nxt = S_SCAN_RD;
        b_nxt = b_r + 1'b1;
        if (rd_q[b_r[5:0]]) begin
          run_nxt = '0;
        end else begin
          if (run_r == 17'd0) begin
            rs_nxt = b_r;
          end
          run_nxt = run_r + 17'd1;
          if (run_r + 17'd1 == want) begin
            ext_we = 1'b1;
            ext_wd = {(run_r == 17'd0) ? b_r[14:0] : rs_r[14:0], 15'(want - 17'd1)};
            n_nxt = n_r + 1'b1;
            rem_nxt = rem_r - want;
            run_nxt = '0;
          end
        end
      end
      S_EMIT_RD: begin
        // ext memory is read this cycle, data valid next
        st_nxt = S_MARK_RD;
        mk_nxt = '0;
      end
      S_MARK_RD: begin
        if (mk_r == 17'd0) begin
          mb_nxt = BAW'(ext_q[29:15]);
          mk_nxt = {2'b0, ext_q[14:0]} + 17'd1;
        end
        rd_a = (mk_r == 17'd0) ? WAW'(ext_q[29:21]) : mb_r[WAW+5:6];
        rd_en = 1'b1;
        st_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        // set every bit of this word that lies in the extent
        wr_en = 1'b1;
        wr_a = mb_r[WAW+5:6];
        wr_d = rd_q;
        for (int k = 0; k < 64; k++) begin
          if (6'(k) >= mb_r[5:0] &&
              (17'(k) - 17'(mb_r[5:0])) < mk_r) begin
            wr_d[k] = 1'b1;
          end
        end
        if (17'(7'd64 - 7'(mb_r[5:0])) >= mk_r) begin
          st_nxt = S_EMIT;
        end else begin
          mk_nxt = mk_r - 17'(7'd64 - 7'(mb_r[5:0]));
          mb_nxt = {mb_r[BAW-1:6] + 1'b1, 6'd0};
          st_nxt = S_MARK_RD;
        end
      end
      S_EMIT: begin
        // output registers load only once the previous transfer has gone
        if (!ov_r) begin
          ov_nxt = 1'b1;
          os_nxt = ext_q[29:15];
          oc_nxt = {1'b0, ext_q[14:0]} + 16'd1;
          ol_nxt = (i_r + 1'b1 == n_r);
          ost_nxt = ST_OK;
          i_nxt = i_r + 1'b1;
          st_nxt = (i_r + 1'b1 == n_r) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_ONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (st_r == S_IDLE))
    else $error("item accepted while busy");
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[30:15] == 16'd0 && out_tlast))
    else $error("failure result carries a count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped");
`endif

endmodule
